// ----- hdl/lfid_pkg.sv -----
// shared types and constants for the lowest-free id allocator
`default_nettype none
package lfid_pkg;

  // table geometry and payload widths
  localparam int ID_BITS      = 8;
  localparam int HANDLE_WIDTH = 32;
  localparam int ID_DEPTH     = 2 ** ID_BITS;
  localparam logic [ID_BITS-1:0] ID_COUNT = ID_BITS'(ID_DEPTH - 1);

  // operation codes
  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC   = 2'd0;
  localparam op_t OP_REMOVE  = 2'd1;
  localparam op_t OP_FIND    = 2'd2;
  localparam op_t OP_REPLACE = 2'd3;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_ZERO   = 2'd1;
  localparam status_t ST_RANGE  = 2'd2;
  localparam status_t ST_UNUSED = 2'd3;

  // request transaction
  typedef struct packed {
    op_t                     op;
    logic [ID_BITS-1:0]      index;
    logic [HANDLE_WIDTH-1:0] handle;
  } lfid_in_t;

  // result transaction
  typedef struct packed {
    status_t                 status;
    logic [ID_BITS-1:0]      out_index;
    logic [HANDLE_WIDTH-1:0] out_handle;
  } lfid_out_t;

endpackage
`default_nettype wire

// ----- hdl/lfid_ram.sv -----
// single-port synchronous ram with registered read data
`default_nettype none
module lfid_ram #(
  parameter int WIDTH = 8,
  parameter int ABITS = 8
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic             we,
  input  wire logic [ABITS-1:0] addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];
  logic [WIDTH-1:0] rdata_r;

  // one access per cycle, read or write
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/lowest_free_id_allocator.sv -----
// top level: sequencer over the handle and subtree-count memories
// One transaction at a time. After reset a clearing pass over all 2^ID_BITS (256) addresses
// zeroes both memories before the first request is taken. Find and replace read the handle
// memory; remove then updates each ancestor count with a read and a write (up to ID_BITS), and
// allocate walks the count tree one synchronous read per node visited (up to about 2*ID_BITS
// nodes) before the same ancestor update. A request rejected at once goes straight to its
// result. The single port of the count memory serialises these reads and writes. A finished
// result waits in an output register while the next request is accepted.
`default_nettype none
module lowest_free_id_allocator
  import lfid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire lfid_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output lfid_out_t      out_data
);

  localparam int IW = ID_BITS;
  localparam int HW = HANDLE_WIDTH;

  // sequencer states
  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_HWAIT   = 4'd2;
  localparam logic [3:0] S_RD_ID   = 4'd3;
  localparam logic [3:0] S_ID      = 4'd4;
  localparam logic [3:0] S_RD_NODE = 4'd5;
  localparam logic [3:0] S_NODE    = 4'd6;
  localparam logic [3:0] S_GRANT   = 4'd7;
  localparam logic [3:0] S_ADJ_RD  = 4'd8;
  localparam logic [3:0] S_ADJ_WR  = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0]    state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [HW-1:0] h_r, h_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [IW-1:0] span_r, span_nxt;
  logic [IW:0]   rsum_r, rsum_nxt;
  logic [IW-1:0] here_r, here_nxt;
  logic [IW:0]   node_r, node_nxt;
  logic [IW-1:0] adj_k_r, adj_k_nxt;
  logic          adj_up_r, adj_up_nxt;
  logic [IW-1:0] hint_r, hint_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  status_t       status_r, status_nxt;
  logic [IW-1:0] oidx_r, oidx_nxt;
  logic [HW-1:0] oh_r, oh_nxt;
  logic          out_valid_r, out_valid_nxt;
  lfid_out_t     out_data_r, out_data_nxt;

  // memory ports
  logic          cnt_en, cnt_we;
  logic [IW-1:0] cnt_addr, cnt_wdata, cnt_rdata;
  logic          hdl_en, hdl_we;
  logic [IW-1:0] hdl_addr;
  logic [HW-1:0] hdl_wdata, hdl_rdata;

  lfid_ram #(.WIDTH(IW), .ABITS(IW)) u_cnt_ram (
    .clk(clk), .en(cnt_en), .we(cnt_we), .addr(cnt_addr),
    .wdata(cnt_wdata), .rdata(cnt_rdata)
  );

  lfid_ram #(.WIDTH(HW), .ABITS(IW)) u_hdl_ram (
    .clk(clk), .en(hdl_en), .we(hdl_we), .addr(hdl_addr),
    .wdata(hdl_wdata), .rdata(hdl_rdata)
  );

  // tree arithmetic
  logic [IW-1:0] id_inc, span_id, id_jump, start_id, node_cnt, adj_base, adj_inc;
  logic [IW:0]   node_sum, rsum_sum;
  logic          node_hit;

  always_comb begin
    id_inc   = id_r + IW'(1);
    id_jump  = id_r | id_inc;
    span_id  = id_r ^ id_jump;
    start_id = (in_data.index > hint_r) ? in_data.index : hint_r;
    node_sum = {1'b0, id_r} + {1'b0, span_r};
    node_cnt = (node_r >= {1'b0, ID_COUNT}) ? '0 : cnt_rdata;
    rsum_sum = rsum_r + {1'b0, node_cnt};
    node_hit = ({1'b0, here_r} == (rsum_sum + {1'b0, span_r}));
    adj_inc  = adj_k_r + IW'(1);
    adj_base = adj_k_r & adj_inc;
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    h_nxt         = h_r;
    id_nxt        = id_r;
    span_nxt      = span_r;
    rsum_nxt      = rsum_r;
    here_nxt      = here_r;
    node_nxt      = node_r;
    adj_k_nxt     = adj_k_r;
    adj_up_nxt    = adj_up_r;
    hint_nxt      = hint_r;
    clr_nxt       = clr_r;
    status_nxt    = status_r;
    oidx_nxt      = oidx_r;
    oh_nxt        = oh_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt_en        = 1'b0;
    cnt_we        = 1'b0;
    cnt_addr      = adj_k_r;
    cnt_wdata     = '0;
    hdl_en        = 1'b0;
    hdl_we        = 1'b0;
    hdl_addr      = idx_r;
    hdl_wdata     = '0;

    // result leaves the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        cnt_en   = 1'b1;
        cnt_we   = 1'b1;
        cnt_addr = clr_r;
        hdl_en   = 1'b1;
        hdl_we   = 1'b1;
        hdl_addr = clr_r;
        clr_nxt  = clr_r + IW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.op;
          idx_nxt    = in_data.index;
          h_nxt      = in_data.handle;
          oidx_nxt   = in_data.index;
          oh_nxt     = '0;
          status_nxt = ST_OK;
          if (in_data.op == OP_ALLOC) begin
            if (in_data.handle == '0) begin
              status_nxt = ST_ZERO;
              state_nxt  = S_FIN;
            end else if (in_data.index >= ID_COUNT) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_FIN;
            end else begin
              id_nxt    = start_id;
              state_nxt = S_RD_ID;
            end
          end else if (in_data.op == OP_REPLACE && in_data.handle == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_FIN;
          end else if (in_data.index >= ID_COUNT) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_FIN;
          end else begin
            hdl_en    = 1'b1;
            hdl_addr  = in_data.index;
            state_nxt = S_HWAIT;
          end
        end
      end
      S_HWAIT: begin
        if (hdl_rdata == '0) begin
          status_nxt = ST_UNUSED;
          state_nxt  = S_FIN;
        end else begin
          oh_nxt = hdl_rdata;
          if (op_r == OP_REMOVE) begin
            hdl_en     = 1'b1;
            hdl_we     = 1'b1;
            adj_k_nxt  = idx_r;
            adj_up_nxt = 1'b0;
            if (idx_r < hint_r) begin
              hint_nxt = idx_r;
            end
            state_nxt = S_ADJ_RD;
          end else if (op_r == OP_REPLACE) begin
            hdl_en    = 1'b1;
            hdl_we    = 1'b1;
            hdl_wdata = h_r;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RD_ID: begin
        if (id_r >= ID_COUNT) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_FIN;
        end else begin
          cnt_en    = 1'b1;
          cnt_addr  = id_r;
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        if (cnt_rdata == '0) begin
          state_nxt = S_GRANT;
        end else if (cnt_rdata == span_id) begin
          id_nxt    = id_jump;
          state_nxt = S_RD_ID;
        end else begin
          here_nxt = cnt_rdata;
          span_nxt = span_id >> 1;
          rsum_nxt = '0;
          if ((span_id >> 1) == '0) begin
            state_nxt = S_GRANT;
          end else begin
            state_nxt = S_RD_NODE;
          end
        end
      end
      S_RD_NODE: begin
        node_nxt  = node_sum;
        cnt_en    = 1'b1;
        cnt_addr  = node_sum[IW-1:0];
        state_nxt = S_NODE;
      end
      S_NODE: begin
        span_nxt = span_r >> 1;
        if (node_hit) begin
          id_nxt   = node_r[IW-1:0];
          here_nxt = node_cnt;
          rsum_nxt = '0;
          if (node_cnt == '0 || (span_r >> 1) == '0) begin
            state_nxt = S_GRANT;
          end else begin
            state_nxt = S_RD_NODE;
          end
        end else begin
          rsum_nxt = rsum_sum;
          if ((span_r >> 1) == '0) begin
            state_nxt = S_GRANT;
          end else begin
            state_nxt = S_RD_NODE;
          end
        end
      end
      S_GRANT: begin
        hdl_en     = 1'b1;
        hdl_we     = 1'b1;
        hdl_addr   = id_r;
        hdl_wdata  = h_r;
        oidx_nxt   = id_r;
        adj_k_nxt  = id_r;
        adj_up_nxt = 1'b1;
        if (idx_r <= hint_r) begin
          hint_nxt = id_r;
        end
        state_nxt = S_ADJ_RD;
      end
      S_ADJ_RD: begin
        cnt_en    = 1'b1;
        state_nxt = S_ADJ_WR;
      end
      S_ADJ_WR: begin
        cnt_en = 1'b1;
        cnt_we = 1'b1;
        if (adj_up_r) begin
          cnt_wdata = cnt_rdata + IW'(1);
        end else if (cnt_rdata != '0) begin
          cnt_wdata = cnt_rdata - IW'(1);
        end else begin
          cnt_wdata = cnt_rdata;
        end
        if (adj_base == '0) begin
          state_nxt = S_FIN;
        end else begin
          adj_k_nxt = adj_base - IW'(1);
          state_nxt = S_ADJ_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.out_index  = oidx_r;
          out_data_nxt.out_handle = (status_r == ST_OK) ? oh_r : '0;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    h_r        <= h_nxt;
    id_r       <= id_nxt;
    span_r     <= span_nxt;
    rsum_r     <= rsum_nxt;
    here_r     <= here_nxt;
    node_r     <= node_nxt;
    adj_k_r    <= adj_k_nxt;
    adj_up_r   <= adj_up_nxt;
    status_r   <= status_nxt;
    oidx_r     <= oidx_nxt;
    oh_r       <= oh_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
